// File: rtl/world_to_screen_projection_defines.svh
// assertion macros for the world to screen projection checker
// expects clk and rst_n in the scope where a macro is used
`ifndef WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH
`define WORLD_TO_SCREEN_PROJECTION_DEFINES_SVH

// same-cycle implication
`define WTSP_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("wtsp check failed");

// next-cycle implication
`define WTSP_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("wtsp check failed");

`endif

// File: rtl/wtsp_pkg.sv
// shared constants, register codes and width helpers for the projection block
// no dependencies
`default_nettype none

package wtsp_pkg;

    localparam int COORD_WIDTH_DEF = 21;
    localparam int FIELD_W         = 21;
    localparam int CFG_W           = 63;
    localparam int CFG_IDX_W       = 4;
    localparam int TAN_W           = 16;
    localparam int SIZE_W          = 14;
    localparam int OUT_W           = 18;
    localparam int POS_W           = 28;
    localparam int DIV_STEPS       = 26;
    localparam int AX_STAGES       = DIV_STEPS + 2;
    localparam int FRONT_STAGES    = 4;
    localparam int DEPTH_MIN_RAW   = 838860;
    localparam int OUT_MAX         = 131071;
    localparam int OUT_MIN         = -131072;

    localparam logic [CFG_W-1:0]  CAM_RST    = '0;
    localparam logic [CFG_W-1:0]  AX_DEP_RST = CFG_W'(1) << 19;
    localparam logic [CFG_W-1:0]  AX_HOR_RST = CFG_W'(1) << (FIELD_W + 19);
    localparam logic [CFG_W-1:0]  AX_VER_RST = CFG_W'(1) << (2 * FIELD_W + 19);
    localparam logic [TAN_W-1:0]  TAN_RST    = TAN_W'(4096);
    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(1920);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(1080);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CAMERA_POSITION = 4'd0,
        CFG_AXIS_DEPTH      = 4'd1,
        CFG_AXIS_HORIZONTAL = 4'd2,
        CFG_AXIS_VERTICAL   = 4'd3,
        CFG_TAN_HALF_FOV_X  = 4'd4,
        CFG_TAN_HALF_FOV_Y  = 4'd5,
        CFG_SCREEN_WIDTH    = 4'd6,
        CFG_SCREEN_HEIGHT   = 4'd7
    } cfg_idx_t;

    // camera-relative difference width
    function automatic int diff_w(input int cw);
        return ((cw > FIELD_W) ? cw : FIELD_W) + 1;
    endfunction

    // dot product width
    function automatic int sum_w(input int cw);
        return diff_w(cw) + FIELD_W + 2;
    endfunction

    // dividend: |lateral| * size * 2^16
    function automatic int num_w(input int cw);
        return sum_w(cw) + SIZE_W + 16;
    endfunction

    // divisor: depth * tangent
    function automatic int den_w(input int cw);
        return sum_w(cw) - 1 + TAN_W;
    endfunction

    function automatic int rem_w(input int cw);
        return (num_w(cw) > den_w(cw) + DIV_STEPS) ? num_w(cw) : den_w(cw) + DIV_STEPS;
    endfunction

    function automatic logic signed [FIELD_W-1:0] lane(input logic [CFG_W-1:0] r,
                                                       input int k);
        return $signed(r[FIELD_W*k +: FIELD_W]);
    endfunction

    function automatic logic signed [OUT_W-1:0] clamp_out(input logic signed [POS_W-1:0] v);
        logic signed [POS_W-1:0] hi;
        logic signed [POS_W-1:0] lo;
        hi = POS_W'(OUT_MAX);
        lo = POS_W'(OUT_MIN);
        if (v > hi)
            return OUT_W'(OUT_MAX);
        else if (v < lo)
            return OUT_W'(OUT_MIN);
        else
            return OUT_W'(v);
    endfunction

endpackage

`default_nettype wire

// File: rtl/wtsp_axis.sv
// one screen axis: pipelined restoring divider, rounding and window offset
// depends on wtsp_pkg
`default_nettype none

module wtsp_axis import wtsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                        clk,
    input  wire logic [AX_STAGES-1:0]        en,
    input  wire logic [num_w(COORD_WIDTH)-1:0] num,
    input  wire logic [den_w(COORD_WIDTH)-1:0] den,
    input  wire logic                        neg,
    input  wire logic [SIZE_W-1:0]           size,
    output logic signed [POS_W-1:0]          pos
);

    localparam int DNW = den_w(COORD_WIDTH);
    localparam int RW  = rem_w(COORD_WIDTH);

    logic [RW-1:0]        rem_reg [DIV_STEPS+1];
    logic [DNW-1:0]       den_reg [DIV_STEPS+1];
    logic [DIV_STEPS-1:0] q_reg   [DIV_STEPS+1];
    logic                 sat_reg [DIV_STEPS+1];
    logic                 neg_reg [DIV_STEPS+1];
    logic signed [POS_W-1:0] pos_reg;

    logic [RW-1:0]        dsh [DIV_STEPS];
    logic [DIV_STEPS-1:0] ge;
    logic                 sat_in;
    logic [DIV_STEPS:0]   q_full;
    logic [DIV_STEPS:0]   term;
    logic [SIZE_W+2:0]    half;

    // quotient caps at 2^26 once the dividend reaches divisor << 26
    assign sat_in = RW'(num) >= (RW'(den) << DIV_STEPS);

    always_comb
    begin
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            dsh[k] = RW'(den_reg[k]) << (DIV_STEPS - 1 - k);
            ge[k]  = rem_reg[k] >= dsh[k];
        end
    end

    assign q_full = sat_reg[DIV_STEPS] ? ((DIV_STEPS+1)'(1) << DIV_STEPS)
                                       : {1'b0, q_reg[DIV_STEPS]};
    // round half away from zero on the magnitude
    assign term   = (q_full + (DIV_STEPS+1)'(1)) >> 1;
    assign half   = {size, 3'b000};

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            rem_reg[0] <= RW'(num);
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            sat_reg[0] <= sat_in;
            neg_reg[0] <= neg;
        end
        for (int k = 0; k < DIV_STEPS; k++)
        begin
            if (en[k+1])
            begin
                rem_reg[k+1] <= ge[k] ? (rem_reg[k] - dsh[k]) : rem_reg[k];
                den_reg[k+1] <= den_reg[k];
                q_reg[k+1]   <= {q_reg[k][DIV_STEPS-2:0], ge[k]};
                sat_reg[k+1] <= sat_reg[k];
                neg_reg[k+1] <= neg_reg[k];
            end
        end
        if (en[DIV_STEPS+1])
        begin
            if (neg_reg[DIV_STEPS])
                pos_reg <= $signed(POS_W'(half)) + $signed(POS_W'(term));
            else
                pos_reg <= $signed(POS_W'(half)) - $signed(POS_W'(term));
        end
    end

    assign pos = pos_reg;

endmodule

`default_nettype wire

// File: rtl/world_to_screen_projection.sv
// throughput: one point per cycle while out_ready is not held low; the 26-step divider pipeline sets the depth
// each stage holds independently, so bubbles close up under output backpressure
// reset: all valid bits clear, camera registers return to their power-on values
// depends on wtsp_pkg and wtsp_axis
`default_nettype none

module world_to_screen_projection import wtsp_pkg::*; #(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic signed [COORD_WIDTH-1:0]  point_x,
    input  wire logic signed [COORD_WIDTH-1:0]  point_y,
    input  wire logic signed [COORD_WIDTH-1:0]  point_z,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic                                visible,
    output logic signed [OUT_W-1:0]             screen_x,
    output logic signed [OUT_W-1:0]             screen_y,
    output logic                                in_window,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]           cfg_index,
    input  wire logic [CFG_W-1:0]               cfg_data
);

    localparam int DW     = diff_w(COORD_WIDTH);
    localparam int PW     = DW + FIELD_W;
    localparam int SW     = sum_w(COORD_WIDTH);
    localparam int NW     = num_w(COORD_WIDTH);
    localparam int DNW    = den_w(COORD_WIDTH);
    localparam int NST    = FRONT_STAGES + AX_STAGES + 1;
    localparam int OUT_ST = NST - 1;
    localparam logic signed [SW-1:0] DEPTH_MIN = SW'(DEPTH_MIN_RAW);

    // configuration registers
    logic [CFG_W-1:0]  cam_reg, ax_dep_reg, ax_hor_reg, ax_ver_reg;
    logic [TAN_W-1:0]  tanx_reg, tany_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;

    logic [NST-1:0] v_reg;
    logic [NST-1:0] en;

    logic signed [COORD_WIDTH-1:0] pt [3];
    logic [CFG_W-1:0]              axis_w [3];

    logic signed [DW-1:0] d_reg    [3];
    logic signed [PW-1:0] prod_reg [3][3];
    logic signed [SW-1:0] sum_reg  [3];

    logic                 neg_h, neg_v;
    logic [SW-1:0]        mag_h, mag_v;
    logic [SW+SIZE_W-1:0] ms_h, ms_v;
    logic [TAN_W-1:0]     tx_eff, ty_eff;

    logic [NW-1:0]  num_h_reg, num_v_reg;
    logic [DNW-1:0] den_h_reg, den_v_reg;
    logic           neg_h_reg, neg_v_reg;
    logic           vis_pipe [AX_STAGES+1];

    logic signed [POS_W-1:0] pos_h, pos_v;
    logic signed [POS_W-1:0] wlim, hlim;

    logic                    visible_reg, in_window_reg;
    logic signed [OUT_W-1:0] screen_x_reg, screen_y_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cam_reg    <= CAM_RST;
            ax_dep_reg <= AX_DEP_RST;
            ax_hor_reg <= AX_HOR_RST;
            ax_ver_reg <= AX_VER_RST;
            tanx_reg   <= TAN_RST;
            tany_reg   <= TAN_RST;
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_CAMERA_POSITION: cam_reg    <= cfg_data;
                CFG_AXIS_DEPTH:      ax_dep_reg <= cfg_data;
                CFG_AXIS_HORIZONTAL: ax_hor_reg <= cfg_data;
                CFG_AXIS_VERTICAL:   ax_ver_reg <= cfg_data;
                CFG_TAN_HALF_FOV_X:  tanx_reg   <= cfg_data[TAN_W-1:0];
                CFG_TAN_HALF_FOV_Y:  tany_reg   <= cfg_data[TAN_W-1:0];
                CFG_SCREEN_WIDTH:    width_reg  <= cfg_data[SIZE_W-1:0];
                CFG_SCREEN_HEIGHT:   height_reg <= cfg_data[SIZE_W-1:0];
                default: ;
            endcase
        end
    end

    // a stage may load when it is empty or its content moves on
    always_comb
    begin
        en[OUT_ST] = !v_reg[OUT_ST] || out_ready;
        for (int i = OUT_ST - 1; i >= 0; i--)
            en[i] = !v_reg[i] || en[i+1];
    end

    assign in_ready = en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= '0;
        else
        begin
            if (en[0])
                v_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                if (en[i])
                    v_reg[i] <= v_reg[i-1];
            end
        end
    end

    assign pt[0]     = point_x;
    assign pt[1]     = point_y;
    assign pt[2]     = point_z;
    assign axis_w[0] = ax_dep_reg;
    assign axis_w[1] = ax_hor_reg;
    assign axis_w[2] = ax_ver_reg;

    assign neg_h  = sum_reg[1][SW-1];
    assign neg_v  = sum_reg[2][SW-1];
    assign mag_h  = neg_h ? SW'(-sum_reg[1]) : SW'(sum_reg[1]);
    assign mag_v  = neg_v ? SW'(-sum_reg[2]) : SW'(sum_reg[2]);
    assign ms_h   = (SW+SIZE_W)'(mag_h) * (SW+SIZE_W)'(width_reg);
    assign ms_v   = (SW+SIZE_W)'(mag_v) * (SW+SIZE_W)'(height_reg);
    // zero tangent counts as the smallest step
    assign tx_eff = (tanx_reg == '0) ? TAN_W'(1) : tanx_reg;
    assign ty_eff = (tany_reg == '0) ? TAN_W'(1) : tany_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int k = 0; k < 3; k++)
                d_reg[k] <= DW'(pt[k]) - DW'(lane(cam_reg, k));
        end
        if (en[1])
        begin
            for (int a = 0; a < 3; a++)
                for (int k = 0; k < 3; k++)
                    prod_reg[a][k] <= PW'(d_reg[k]) * PW'(lane(axis_w[a], k));
        end
        if (en[2])
        begin
            for (int a = 0; a < 3; a++)
                sum_reg[a] <= SW'(prod_reg[a][0]) + SW'(prod_reg[a][1])
                            + SW'(prod_reg[a][2]);
        end
        if (en[3])
        begin
            vis_pipe[0] <= sum_reg[0] > DEPTH_MIN;
            neg_h_reg   <= neg_h;
            neg_v_reg   <= neg_v;
            num_h_reg   <= {ms_h, 16'h0000};
            num_v_reg   <= {ms_v, 16'h0000};
            den_h_reg   <= DNW'(sum_reg[0][SW-2:0]) * DNW'(tx_eff);
            den_v_reg   <= DNW'(sum_reg[0][SW-2:0]) * DNW'(ty_eff);
        end
        for (int j = 0; j < AX_STAGES; j++)
        begin
            if (en[FRONT_STAGES+j])
                vis_pipe[j+1] <= vis_pipe[j];
        end
    end

    wtsp_axis #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_h (
        .clk  (clk),
        .en   (en[FRONT_STAGES +: AX_STAGES]),
        .num  (num_h_reg),
        .den  (den_h_reg),
        .neg  (neg_h_reg),
        .size (width_reg),
        .pos  (pos_h)
    );

    wtsp_axis #(
        .COORD_WIDTH (COORD_WIDTH)
    ) u_axis_v (
        .clk  (clk),
        .en   (en[FRONT_STAGES +: AX_STAGES]),
        .num  (num_v_reg),
        .den  (den_v_reg),
        .neg  (neg_v_reg),
        .size (height_reg),
        .pos  (pos_v)
    );

    assign wlim = $signed(POS_W'({width_reg, 4'h0}));
    assign hlim = $signed(POS_W'({height_reg, 4'h0}));

    // window test runs on the unclamped position
    always_ff @(posedge clk)
    begin
        if (en[OUT_ST])
        begin
            visible_reg <= vis_pipe[AX_STAGES];
            if (vis_pipe[AX_STAGES])
            begin
                screen_x_reg  <= clamp_out(pos_h);
                screen_y_reg  <= clamp_out(pos_v);
                in_window_reg <= (pos_h > 0) && (pos_h <= wlim)
                              && (pos_v > 0) && (pos_v <= hlim);
            end
            else
            begin
                screen_x_reg  <= '0;
                screen_y_reg  <= '0;
                in_window_reg <= 1'b0;
            end
        end
    end

    assign out_valid = v_reg[OUT_ST];
    assign visible   = visible_reg;
    assign screen_x  = screen_x_reg;
    assign screen_y  = screen_y_reg;
    assign in_window = in_window_reg;

endmodule

`default_nettype wire

// File: rtl/wtsp_checker.sv
// port-level checks for world_to_screen_projection, attached by bind
// depends on wtsp_pkg and world_to_screen_projection_defines.svh
`default_nettype none
`include "world_to_screen_projection_defines.svh"

module wtsp_checker import wtsp_pkg::*; (
    input wire logic                    clk,
    input wire logic                    rst_n,
    input wire logic                    out_valid,
    input wire logic                    out_ready,
    input wire logic                    visible,
    input wire logic signed [OUT_W-1:0] screen_x,
    input wire logic signed [OUT_W-1:0] screen_y,
    input wire logic                    in_window
);

    // a stalled result holds its value
    `WTSP_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(screen_x) && $stable(screen_y) && $stable(visible) && $stable(in_window))

    // points behind the near limit report all zero
    `WTSP_ASSERT_SAME(a_hidden_zero, out_valid && !visible, (screen_x == 0) && (screen_y == 0) && !in_window)

    // on-window points are visible and strictly positive
    `WTSP_ASSERT_SAME(a_window_pos, out_valid && in_window, visible && (screen_x > 0) && (screen_y > 0))

endmodule

bind world_to_screen_projection wtsp_checker u_wtsp_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .visible   (visible),
    .screen_x  (screen_x),
    .screen_y  (screen_y),
    .in_window (in_window)
);

`default_nettype wire
